// ===== rtl/core/gate_stream_peephole_optimizer_unit_assert.svh =====
// Assertion macros for the gate stream peephole optimizer.
`ifndef GATE_STREAM_PEEPHOLE_OPTIMIZER_UNIT_ASSERT_SVH
`define GATE_STREAM_PEEPHOLE_OPTIMIZER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define GSPO_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define GSPO_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define GSPO_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define GSPO_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/core/gspo_pkg.sv =====
`default_nettype none

package gspo_pkg;

   localparam int QUBIT_BITS = 8;
   localparam int ANGLE_BITS = 32;

   localparam int KIND_BITS       = 4;
   localparam int TAG_BITS        = 16;
   localparam int EPS_BITS        = 16;
   localparam int PORT_ANGLE_BITS = 32;
   localparam int PORT_QUBIT_BITS = 8;

   localparam logic [KIND_BITS-1:0] KIND_RZ     = 4'd2;
   localparam logic [KIND_BITS-1:0] KIND_CX     = 4'd3;
   localparam logic [KIND_BITS-1:0] KIND_CU1    = 4'd4;
   localparam logic [KIND_BITS-1:0] KIND_H      = 4'd5;
   localparam logic [KIND_BITS-1:0] KIND_OPAQUE = 4'd9;

   localparam int OPQ_DEPTH     = 4;
   localparam int OPQ_PTR_BITS  = $clog2(OPQ_DEPTH);
   localparam int OPQ_CNT_BITS  = $clog2(OPQ_DEPTH + 1);
   localparam int OUTQ_DEPTH    = 4;
   localparam int OUTQ_PTR_BITS = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CNT_BITS = $clog2(OUTQ_DEPTH + 1);

   typedef struct packed {
      logic [KIND_BITS-1:0]  kind;
      logic [ANGLE_BITS-1:0] angle;
      logic [QUBIT_BITS-1:0] qa;
      logic [QUBIT_BITS-1:0] qb;
      logic [TAG_BITS-1:0]   tag;
   } gate_type;

   typedef enum logic {
      OP_PUSH,
      OP_END
   } op_kind_type;

   typedef struct packed {
      op_kind_type op;
      logic        in_flush;
      gate_type    gate;
   } op_entry_type;

   typedef struct packed {
      gate_type gate;
      logic     last;
   } rsp_entry_type;

   typedef struct packed {
      logic flushing;
      logic fuse_valid;
      logic cancel_valid;
   } front_status_type;

   typedef struct packed {
      logic                     h_valid;
      logic                     hold_valid;
      logic [OUTQ_CNT_BITS-1:0] out_count;
   } back_status_type;

   function automatic logic is_rot(logic [KIND_BITS-1:0] kind);
      return kind <= KIND_RZ;
   endfunction

   function automatic logic [ANGLE_BITS-1:0] angle_in(logic [PORT_ANGLE_BITS-1:0] a);
      logic signed [PORT_ANGLE_BITS-1:0] s;
      logic signed [63:0]                w;
      s = a;
      w = 64'(s);
      return w[ANGLE_BITS-1:0];
   endfunction

   function automatic logic [PORT_ANGLE_BITS-1:0] angle_out(logic [ANGLE_BITS-1:0] a);
      logic signed [ANGLE_BITS-1:0] s;
      logic signed [63:0]           w;
      s = a;
      w = 64'(s);
      return w[PORT_ANGLE_BITS-1:0];
   endfunction

   function automatic logic [QUBIT_BITS-1:0] qubit_in(logic [PORT_QUBIT_BITS-1:0] q);
      logic [31:0] w;
      w = 32'(q);
      return w[QUBIT_BITS-1:0];
   endfunction

   function automatic logic [PORT_QUBIT_BITS-1:0] qubit_out(logic [QUBIT_BITS-1:0] q);
      logic [31:0] w;
      w = 32'(q);
      return w[PORT_QUBIT_BITS-1:0];
   endfunction

   function automatic gate_type h_gate(logic [QUBIT_BITS-1:0] q);
      gate_type g;
      g      = '0;
      g.kind = KIND_H;
      g.qa   = q;
      return g;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gspo_front.sv =====
`default_nettype none

module gspo_front
   import gspo_pkg::*;
(
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_push,
   output logic                                   req_full,
   input  wire logic                              req_command,
   input  wire logic [KIND_BITS-1:0]              req_gate_kind,
   input  wire logic signed [PORT_ANGLE_BITS-1:0] req_angle,
   input  wire logic [PORT_QUBIT_BITS-1:0]        req_qubit_a,
   input  wire logic [PORT_QUBIT_BITS-1:0]        req_qubit_b,
   input  wire logic [TAG_BITS-1:0]               req_raw_tag,
   input  wire logic                              op_full,
   output logic                                   op_valid,
   output op_entry_type                           op_data,
   output front_status_type                       status
);

   logic     flushing_ff, flushing_in;
   logic     fuse_valid_ff, fuse_valid_in;
   logic     cancel_valid_ff, cancel_valid_in;
   gate_type fuse_ff, fuse_in;
   gate_type cancel_ff, cancel_in;

   gate_type g;
   logic     accept;
   logic     can_fuse;
   logic     pair_cancels;
   logic     advance_fuse;
   logic     advance_flag;

   // Clear fields that the gate kind does not use.
   always_comb begin
      g      = '0;
      g.kind = req_gate_kind;
      if (is_rot(req_gate_kind) || req_gate_kind == KIND_CU1) begin
         g.angle = angle_in(req_angle);
      end
      if (req_gate_kind < KIND_OPAQUE) begin
         g.qa = qubit_in(req_qubit_a);
      end
      if (req_gate_kind == KIND_CX || req_gate_kind == KIND_CU1) begin
         g.qb = qubit_in(req_qubit_b);
      end
      if (req_gate_kind >= KIND_OPAQUE) begin
         g.tag = req_raw_tag;
      end
   end

   assign req_full = flushing_ff | op_full;
   assign accept   = req_push & ~req_full;

   assign can_fuse = fuse_valid_ff && is_rot(g.kind) && fuse_ff.kind == g.kind
                     && fuse_ff.qa == g.qa;
   assign pair_cancels = cancel_ff.kind == KIND_CX && fuse_ff.kind == KIND_CX
                         && cancel_ff.qa == fuse_ff.qa && cancel_ff.qb == fuse_ff.qb;

   always_comb begin
      flushing_in     = flushing_ff;
      fuse_valid_in   = fuse_valid_ff;
      cancel_valid_in = cancel_valid_ff;
      fuse_in         = fuse_ff;
      cancel_in       = cancel_ff;
      op_valid        = 1'b0;
      op_data         = '{op: OP_PUSH, in_flush: 1'b0, gate: cancel_ff};
      advance_fuse    = 1'b0;
      advance_flag    = 1'b0;

      if (flushing_ff) begin
         if (!op_full) begin
            if (fuse_valid_ff) begin
               fuse_valid_in = 1'b0;
               advance_fuse  = 1'b1;
               advance_flag  = 1'b1;
            end else if (cancel_valid_ff) begin
               cancel_valid_in = 1'b0;
               op_valid        = 1'b1;
               op_data         = '{op: OP_PUSH, in_flush: 1'b1, gate: cancel_ff};
            end else begin
               op_valid    = 1'b1;
               op_data     = '{op: OP_END, in_flush: 1'b1, gate: cancel_ff};
               flushing_in = 1'b0;
            end
         end
      end else if (accept) begin
         if (req_command) begin
            flushing_in = 1'b1;
         end else if (can_fuse) begin
            fuse_in.angle = fuse_ff.angle + g.angle;
         end else begin
            advance_fuse  = fuse_valid_ff;
            fuse_in       = g;
            fuse_valid_in = 1'b1;
         end
      end

      // Move the fuse gate into the cancel slot, dropping a matching cx pair.
      if (advance_fuse) begin
         if (cancel_valid_ff && pair_cancels) begin
            cancel_valid_in = 1'b0;
         end else begin
            if (cancel_valid_ff) begin
               op_valid = 1'b1;
               op_data  = '{op: OP_PUSH, in_flush: advance_flag, gate: cancel_ff};
            end
            cancel_in       = fuse_ff;
            cancel_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flushing_ff     <= 1'b0;
         fuse_valid_ff   <= 1'b0;
         cancel_valid_ff <= 1'b0;
      end else begin
         flushing_ff     <= flushing_in;
         fuse_valid_ff   <= fuse_valid_in;
         cancel_valid_ff <= cancel_valid_in;
      end
      fuse_ff   <= fuse_in;
      cancel_ff <= cancel_in;
   end

   assign status = '{flushing: flushing_ff, fuse_valid: fuse_valid_ff,
                     cancel_valid: cancel_valid_ff};

endmodule

`default_nettype wire

// ===== rtl/core/gspo_op_queue.sv =====
`default_nettype none

module gspo_op_queue
   import gspo_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  op_entry_type       push_data,
   output logic               full,
   input  wire logic          pop,
   output logic               empty,
   output op_entry_type       head
);

   op_entry_type              entries_ff [OPQ_DEPTH];
   logic [OPQ_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [OPQ_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [OPQ_CNT_BITS-1:0]   count_ff, count_in;
   logic                      do_push, do_pop;

   assign full    = count_ff == OPQ_CNT_BITS'(OPQ_DEPTH);
   assign empty   = count_ff == '0;
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == OPQ_PTR_BITS'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == OPQ_PTR_BITS'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/gspo_back.sv =====
`default_nettype none

module gspo_back
   import gspo_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [EPS_BITS-1:0]         zero_angle_eps,
   input  wire logic                        op_empty,
   input  op_entry_type                     op_head,
   output logic                             op_pop,
   output logic                             rsp_empty,
   input  wire logic                        rsp_pop,
   output logic [KIND_BITS-1:0]             rsp_out_kind,
   output logic signed [PORT_ANGLE_BITS-1:0] rsp_out_angle,
   output logic [PORT_QUBIT_BITS-1:0]       rsp_out_qubit_a,
   output logic [PORT_QUBIT_BITS-1:0]       rsp_out_qubit_b,
   output logic [TAG_BITS-1:0]              rsp_out_raw_tag,
   output logic                             rsp_last_of_circuit,
   output back_status_type                  status
);

   logic                     h_valid_ff, h_valid_in;
   logic [QUBIT_BITS-1:0]    h_qubit_ff, h_qubit_in;
   logic                     hold_valid_ff, hold_valid_in;
   gate_type                 hold_ff, hold_in;

   rsp_entry_type            out_entries_ff [OUTQ_DEPTH];
   logic [OUTQ_PTR_BITS-1:0] out_wr_ff, out_wr_in;
   logic [OUTQ_PTR_BITS-1:0] out_rd_ff, out_rd_in;
   logic [OUTQ_CNT_BITS-1:0] out_count_ff, out_count_in;

   gate_type                 g;
   logic [ANGLE_BITS-1:0]    magnitude;
   logic                     zero_rot;
   logic                     out_full;
   logic                     step;
   logic                     emit;
   logic                     emit_flush;
   gate_type                 emit_gate;
   logic                     wr_valid;
   rsp_entry_type            wr_data;
   logic                     rd_take;
   rsp_entry_type            out_head;

   assign g         = op_head.gate;
   assign magnitude = g.angle[ANGLE_BITS-1] ? (~g.angle + 1'b1) : g.angle;
   assign zero_rot  = is_rot(g.kind) && (64'(magnitude) <= 64'(zero_angle_eps));

   assign out_full = out_count_ff == OUTQ_CNT_BITS'(OUTQ_DEPTH);
   assign step     = ~op_empty & ~out_full;

   always_comb begin
      h_valid_in    = h_valid_ff;
      h_qubit_in    = h_qubit_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      op_pop        = 1'b0;
      emit          = 1'b0;
      emit_flush    = op_head.in_flush;
      emit_gate     = g;
      wr_valid      = 1'b0;
      wr_data       = '{gate: hold_ff, last: 1'b0};

      if (step) begin
         if (op_head.op == OP_PUSH) begin
            if (h_valid_ff) begin
               h_valid_in = 1'b0;
               if (g.kind == KIND_H && g.qa == h_qubit_ff) begin
                  op_pop = 1'b1;
               end else begin
                  // Release the waiting h; the gate itself stays at the queue head for a later step.
                  emit      = 1'b1;
                  emit_gate = h_gate(h_qubit_ff);
               end
            end else begin
               op_pop = 1'b1;
               if (zero_rot) begin
               end else if (g.kind == KIND_H) begin
                  h_valid_in = 1'b1;
                  h_qubit_in = g.qa;
               end else begin
                  emit = 1'b1;
               end
            end
         end else begin
            if (h_valid_ff) begin
               h_valid_in = 1'b0;
               emit       = 1'b1;
               emit_gate  = h_gate(h_qubit_ff);
               emit_flush = 1'b1;
            end else begin
               op_pop = 1'b1;
               if (hold_valid_ff) begin
                  wr_valid      = 1'b1;
                  wr_data       = '{gate: hold_ff, last: 1'b1};
                  hold_valid_in = 1'b0;
               end
            end
         end
      end

      // During a flush keep one result back so the final one can be marked.
      if (emit) begin
         if (emit_flush) begin
            if (hold_valid_ff) begin
               wr_valid = 1'b1;
               wr_data  = '{gate: hold_ff, last: 1'b0};
            end
            hold_in       = emit_gate;
            hold_valid_in = 1'b1;
         end else begin
            wr_valid = 1'b1;
            wr_data  = '{gate: emit_gate, last: 1'b0};
         end
      end
   end

   assign rsp_empty = out_count_ff == '0;
   assign rd_take   = rsp_pop & ~rsp_empty;

   always_comb begin
      out_wr_in    = out_wr_ff;
      out_rd_in    = out_rd_ff;
      out_count_in = out_count_ff;
      if (wr_valid) begin
         out_wr_in = (out_wr_ff == OUTQ_PTR_BITS'(OUTQ_DEPTH - 1)) ? '0 : out_wr_ff + 1'b1;
      end
      if (rd_take) begin
         out_rd_in = (out_rd_ff == OUTQ_PTR_BITS'(OUTQ_DEPTH - 1)) ? '0 : out_rd_ff + 1'b1;
      end
      if (wr_valid && !rd_take) begin
         out_count_in = out_count_ff + 1'b1;
      end else if (rd_take && !wr_valid) begin
         out_count_in = out_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff    <= 1'b0;
         hold_valid_ff <= 1'b0;
         out_wr_ff     <= '0;
         out_rd_ff     <= '0;
         out_count_ff  <= '0;
      end else begin
         h_valid_ff    <= h_valid_in;
         hold_valid_ff <= hold_valid_in;
         out_wr_ff     <= out_wr_in;
         out_rd_ff     <= out_rd_in;
         out_count_ff  <= out_count_in;
      end
      h_qubit_ff <= h_qubit_in;
      hold_ff    <= hold_in;
      if (wr_valid) begin
         out_entries_ff[out_wr_ff] <= wr_data;
      end
   end

   assign out_head            = out_entries_ff[out_rd_ff];
   assign rsp_out_kind        = out_head.gate.kind;
   assign rsp_out_angle       = angle_out(out_head.gate.angle);
   assign rsp_out_qubit_a     = qubit_out(out_head.gate.qa);
   assign rsp_out_qubit_b     = qubit_out(out_head.gate.qb);
   assign rsp_out_raw_tag     = out_head.gate.tag;
   assign rsp_last_of_circuit = out_head.last;

   assign status = '{h_valid: h_valid_ff, hold_valid: hold_valid_ff,
                     out_count: out_count_ff};

endmodule

`default_nettype wire

// ===== rtl/core/gate_stream_peephole_optimizer_unit.sv =====
// Peephole optimizer for a parsed stream of quantum gates.
// Input channel (req_*): push one gate, or an end-of-circuit command, per transfer
// whenever req_full is low. Result channel (rsp_*): the oldest emitted gate waits
// on the rsp_ ports while rsp_empty is low; pop it with rsp_pop.
// csr_we/csr_wdata write the zero-angle threshold; write it only while idle.
// The front takes one gate per cycle while req_full is low, fuses rotations and
// cancels cx pairs, then hands each released gate to a 4-entry op queue. The back
// drops zero rotations and h;h pairs and feeds a 4-entry result queue.
// A released gate passes through the op queue and then the result queue before it
// can be popped; a waiting h goes out ahead of it. Gates stay held in the
// fuse/cancel slots until a later gate or an end command pushes them out.
// The back releases a waiting h before it takes the op behind it, and stops while
// the result queue is full. An end command holds the input while the front drains
// its two slots and sends the end op, and for longer while the op queue is full.
// Reset clears all pending gates, both queues and the threshold (0).
// When the receiver stalls, the result queue fills, the back stops, the op queue
// fills and req_full rises; nothing is dropped.
`default_nettype none
`include "gate_stream_peephole_optimizer_unit_assert.svh"

module gate_stream_peephole_optimizer_unit
   import gspo_pkg::*;
(
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_push,
   output logic                                   req_full,
   input  wire logic                              req_command,
   input  wire logic [KIND_BITS-1:0]              req_gate_kind,
   input  wire logic signed [PORT_ANGLE_BITS-1:0] req_angle,
   input  wire logic [PORT_QUBIT_BITS-1:0]        req_qubit_a,
   input  wire logic [PORT_QUBIT_BITS-1:0]        req_qubit_b,
   input  wire logic [TAG_BITS-1:0]               req_raw_tag,
   output logic                                   rsp_empty,
   input  wire logic                              rsp_pop,
   output logic [KIND_BITS-1:0]                   rsp_out_kind,
   output logic signed [PORT_ANGLE_BITS-1:0]      rsp_out_angle,
   output logic [PORT_QUBIT_BITS-1:0]             rsp_out_qubit_a,
   output logic [PORT_QUBIT_BITS-1:0]             rsp_out_qubit_b,
   output logic [TAG_BITS-1:0]                    rsp_out_raw_tag,
   output logic                                   rsp_last_of_circuit,
   input  wire logic                              csr_we,
   input  wire logic [EPS_BITS-1:0]               csr_wdata
);

   // Threshold register: rotations with magnitude at or below it are identities.
   logic [EPS_BITS-1:0] zero_angle_eps_ff, zero_angle_eps_in;

   logic             op_push;
   op_entry_type     op_push_data;
   logic             op_full;
   logic             op_pop;
   logic             op_empty;
   op_entry_type     op_head;
   front_status_type front_status;
   back_status_type  back_status;

   assign zero_angle_eps_in = csr_we ? csr_wdata : zero_angle_eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_angle_eps_ff <= '0;
      end else begin
         zero_angle_eps_ff <= zero_angle_eps_in;
      end
   end

   // Front: classify items, fuse rotations, cancel cx pairs, sequence flushes.
   gspo_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_command   (req_command),
      .req_gate_kind (req_gate_kind),
      .req_angle     (req_angle),
      .req_qubit_a   (req_qubit_a),
      .req_qubit_b   (req_qubit_b),
      .req_raw_tag   (req_raw_tag),
      .op_full       (op_full),
      .op_valid      (op_push),
      .op_data       (op_push_data),
      .status        (front_status)
   );

   // Decouple front and back so either side can stall alone.
   gspo_op_queue u_op_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_data (op_push_data),
      .full      (op_full),
      .pop       (op_pop),
      .empty     (op_empty),
      .head      (op_head)
   );

   // Back: drop zero rotations and h;h pairs, mark the final gate of a flush.
   gspo_back u_back (
      .clock               (clock),
      .reset               (reset),
      .zero_angle_eps      (zero_angle_eps_ff),
      .op_empty            (op_empty),
      .op_head             (op_head),
      .op_pop              (op_pop),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_out_kind        (rsp_out_kind),
      .rsp_out_angle       (rsp_out_angle),
      .rsp_out_qubit_a     (rsp_out_qubit_a),
      .rsp_out_qubit_b     (rsp_out_qubit_b),
      .rsp_out_raw_tag     (rsp_out_raw_tag),
      .rsp_last_of_circuit (rsp_last_of_circuit),
      .status              (back_status)
   );

   // Hold the input off for the whole flush sequence.
   `GSPO_ASSERT_IMP(a_flush_blocks_input, clock, reset, front_status.flushing, req_full, "input open during flush")
   // An accepted end command starts the flush sequence.
   `GSPO_ASSERT_NEXT(a_end_starts_flush, clock, reset, req_push && !req_full && req_command, front_status.flushing, "end command did not start flush")
   // A finished flush leaves both front slots empty.
   `GSPO_ASSERT_IMP(a_flush_drains_front, clock, reset, $fell(front_status.flushing), !front_status.fuse_valid && !front_status.cancel_valid, "flush left a pending gate")
   // A held flush result always has its end op still ahead.
   `GSPO_ASSERT_IMP(a_hold_has_end, clock, reset, back_status.hold_valid, front_status.flushing || !op_empty, "held result without pending end op")

endmodule

`default_nettype wire

// ===== verif/tb_gate_stream_peephole_optimizer_unit.sv =====
`timescale 1ns / 1ps

module tb_gate_stream_peephole_optimizer_unit;
   import gspo_pkg::*;

   // Gate codes that the package leaves unnamed.
   localparam logic [KIND_BITS-1:0] KIND_RX        = 4'd0;
   localparam logic [KIND_BITS-1:0] KIND_RY        = 4'd1;
   localparam logic [KIND_BITS-1:0] KIND_X         = 4'd6;
   localparam logic [KIND_BITS-1:0] KIND_Z         = 4'd7;
   localparam logic [KIND_BITS-1:0] KIND_Y         = 4'd8;
   localparam logic [KIND_BITS-1:0] KIND_LAST_CODE = 4'd15;

   localparam int RESET_CYCLES  = 12;
   // An end command can hold the front while it drains its slots and the back
   // releases a waiting h ahead of an op, so let the pipeline settle this long after the last result.
   localparam int SETTLE_CYCLES = 12;
   localparam int STALL_LIMIT   = 2000;
   localparam int PHASE_COUNT   = 6;
   localparam int PHASE_ITEMS   = 58;

   // Predict the optimized gate stream and compare each popped gate with it.
   class peephole_scoreboard;
      logic [EPS_BITS-1:0]   eps = '0;
      gate_type              fuse_gate = '0;
      bit                    fuse_valid = 1'b0;
      gate_type              cancel_gate = '0;
      bit                    cancel_valid = 1'b0;
      bit                    h_valid = 1'b0;
      logic [QUBIT_BITS-1:0] h_qubit = '0;
      rsp_entry_type         expected_q[$];
      int errors = 0;
      int items = 0;
      int flushes = 0;
      int checked = 0;
      int fused = 0;
      int cx_pairs = 0;
      int h_pairs = 0;
      int zero_drops = 0;

      function int pending();
         return expected_q.size();
      endfunction

      function void emit(gate_type g);
         rsp_entry_type e;
         e.gate = g;
         e.last = 1'b0;
         expected_q.insert(expected_q.size(), e);
      endfunction

      function void release_h();
         gate_type g;
         g = '0;
         g.kind = KIND_H;
         g.qa = h_qubit;
         h_valid = 1'b0;
         emit(g);
      endfunction

      // Back stage: drop identity rotations and h;h on one qubit.
      function void hadamard_stage(gate_type g);
         logic [ANGLE_BITS-1:0] mag;
         if (h_valid) begin
            if (g.kind == KIND_H && g.qa == h_qubit) begin
               h_valid = 1'b0;
               h_pairs++;
               return;
            end
            release_h();
         end
         mag = g.angle[ANGLE_BITS-1] ? (~g.angle + 1'b1) : g.angle;
         if (g.kind <= KIND_RZ && mag <= ANGLE_BITS'(eps)) begin
            zero_drops++;
            return;
         end
         if (g.kind == KIND_H) begin
            h_valid = 1'b1;
            h_qubit = g.qa;
            return;
         end
         emit(g);
      endfunction

      // Middle stage: drop an adjacent matching cx pair.
      function void cancel_stage(gate_type g);
         if (cancel_valid) begin
            if (cancel_gate.kind == KIND_CX && g.kind == KIND_CX &&
                cancel_gate.qa == g.qa && cancel_gate.qb == g.qb) begin
               cancel_valid = 1'b0;
               cx_pairs++;
               return;
            end
            hadamard_stage(cancel_gate);
         end
         cancel_gate = g;
         cancel_valid = 1'b1;
      endfunction

      // Front stage: sum same-kind rotations on one qubit.
      function void fuse_stage(gate_type g);
         if (fuse_valid) begin
            if (g.kind <= KIND_RZ && fuse_gate.kind == g.kind && fuse_gate.qa == g.qa) begin
               fuse_gate.angle = fuse_gate.angle + g.angle;
               fused++;
               return;
            end
            cancel_stage(fuse_gate);
         end
         fuse_gate = g;
         fuse_valid = 1'b1;
      endfunction

      function void note_request(op_kind_type op, gate_type raw);
         gate_type g;
         int       start_size;
         items++;
         if (op == OP_END) begin
            flushes++;
            start_size = expected_q.size();
            if (fuse_valid) begin
               fuse_valid = 1'b0;
               cancel_stage(fuse_gate);
            end
            if (cancel_valid) begin
               cancel_valid = 1'b0;
               hadamard_stage(cancel_gate);
            end
            if (h_valid) release_h();
            // Mark the final gate of the flush.
            if (expected_q.size() > start_size) begin
               expected_q[expected_q.size() - 1].last = 1'b1;
            end
            return;
         end
         // Zero every field that the kind does not use.
         g = '0;
         g.kind = raw.kind;
         if (raw.kind <= KIND_RZ || raw.kind == KIND_CU1) g.angle = raw.angle;
         if (raw.kind < KIND_OPAQUE) g.qa = raw.qa;
         if (raw.kind == KIND_CX || raw.kind == KIND_CU1) g.qb = raw.qb;
         if (raw.kind >= KIND_OPAQUE) g.tag = raw.tag;
         fuse_stage(g);
      endfunction

      function void compare_field(string label, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, label, want, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_entry_type got);
         rsp_entry_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected gate, expected none actual kind %0d qa %0d tag %h",
                     $time, got.gate.kind, got.gate.qa, got.gate.tag);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         checked++;
         compare_field("out_kind", 32'(want.gate.kind), 32'(got.gate.kind));
         compare_field("out_angle", 32'(want.gate.angle), 32'(got.gate.angle));
         compare_field("out_qubit_a", 32'(want.gate.qa), 32'(got.gate.qa));
         compare_field("out_qubit_b", 32'(want.gate.qb), 32'(got.gate.qb));
         compare_field("out_raw_tag", 32'(want.gate.tag), 32'(got.gate.tag));
         compare_field("last_of_circuit", 32'(want.last), 32'(got.last));
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_push = 1'b0;
   logic                              req_full;
   logic                              req_command = 1'b0;
   logic [KIND_BITS-1:0]              req_gate_kind = '0;
   logic signed [PORT_ANGLE_BITS-1:0] req_angle = '0;
   logic [PORT_QUBIT_BITS-1:0]        req_qubit_a = '0;
   logic [PORT_QUBIT_BITS-1:0]        req_qubit_b = '0;
   logic [TAG_BITS-1:0]               req_raw_tag = '0;
   logic                              rsp_empty;
   logic                              rsp_pop = 1'b0;
   logic [KIND_BITS-1:0]              rsp_out_kind;
   logic signed [PORT_ANGLE_BITS-1:0] rsp_out_angle;
   logic [PORT_QUBIT_BITS-1:0]        rsp_out_qubit_a;
   logic [PORT_QUBIT_BITS-1:0]        rsp_out_qubit_b;
   logic [TAG_BITS-1:0]               rsp_out_raw_tag;
   logic                              rsp_last_of_circuit;
   logic                              csr_we = 1'b0;
   logic [EPS_BITS-1:0]               csr_wdata = '0;

   peephole_scoreboard sb = new;

   bit tx_gaps = 1'b0;
   bit rx_gaps = 1'b0;
   int stall_left = 0;
   int quiet_cycles = 0;
   int eps_settings = 0;

   // Previous gate, used to build fusable and cancelling runs.
   logic [KIND_BITS-1:0]       prev_kind = KIND_RX;
   logic [31:0]                prev_angle = '0;
   logic [PORT_QUBIT_BITS-1:0] prev_qa = '0;
   logic [PORT_QUBIT_BITS-1:0] prev_qb = '0;

   gate_stream_peephole_optimizer_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_command         (req_command),
      .req_gate_kind       (req_gate_kind),
      .req_angle           (req_angle),
      .req_qubit_a         (req_qubit_a),
      .req_qubit_b         (req_qubit_b),
      .req_raw_tag         (req_raw_tag),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_out_kind        (rsp_out_kind),
      .rsp_out_angle       (rsp_out_angle),
      .rsp_out_qubit_a     (rsp_out_qubit_a),
      .rsp_out_qubit_b     (rsp_out_qubit_b),
      .rsp_out_raw_tag     (rsp_out_raw_tag),
      .rsp_last_of_circuit (rsp_last_of_circuit),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata)
   );

   always #5 clock = ~clock;

   // Receiver: check each popped gate, then decide whether to stall the next cycle.
   always @(posedge clock) begin
      rsp_entry_type got;
      if (!reset && rsp_pop && !rsp_empty) begin
         got.gate.kind  = rsp_out_kind;
         got.gate.angle = rsp_out_angle;
         got.gate.qa    = rsp_out_qubit_a;
         got.gate.qb    = rsp_out_qubit_b;
         got.gate.tag   = rsp_out_raw_tag;
         got.last       = rsp_last_of_circuit;
         sb.check_result(got);
      end
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_pop <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 6) == 0) begin
         // Start a stall burst that includes this cycle; stall_left counts the rest of it.
         stall_left = $urandom_range(1, 14) - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // Watchdog: end the run once nothing has moved on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("FAIL gate_stream_peephole_optimizer_unit");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [KIND_BITS-1:0] rnd_kind();
      return KIND_BITS'($urandom);
   endfunction

   function automatic logic [PORT_QUBIT_BITS-1:0] rnd_qb();
      return PORT_QUBIT_BITS'($urandom);
   endfunction

   function automatic logic [TAG_BITS-1:0] rnd_tag();
      return TAG_BITS'($urandom);
   endfunction

   // Drive one item and hold it until the transfer happens; note it for prediction.
   task automatic send_item(op_kind_type op, logic [KIND_BITS-1:0] kind, logic [31:0] angle,
                            logic [PORT_QUBIT_BITS-1:0] qa, logic [PORT_QUBIT_BITS-1:0] qb,
                            logic [TAG_BITS-1:0] tag);
      gate_type raw;
      if (tx_gaps && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_push      <= 1'b1;
      req_command   <= op;
      req_gate_kind <= kind;
      req_angle     <= angle;
      req_qubit_a   <= qa;
      req_qubit_b   <= qb;
      req_raw_tag   <= tag;
      do @(posedge clock); while (req_full);
      raw.kind  = kind;
      raw.angle = angle;
      raw.qa    = qa;
      raw.qb    = qb;
      raw.tag   = tag;
      sb.note_request(op, raw);
   endtask

   // Hold the sender until every predicted gate has been popped.
   task automatic wait_drained();
      req_push <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_eps(logic [EPS_BITS-1:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.eps = value;
      eps_settings++;
   endtask

   // Small signed angle around zero, reaching a little past the threshold.
   function automatic logic [31:0] near_zero();
      logic [31:0] v;
      v = $urandom_range(0, 32'(sb.eps) + 2);
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   function automatic logic [31:0] pick_angle();
      case ($urandom_range(0, 6))
         0: return '0;
         1: return 32'h8000_0000;
         2: return 32'h7fff_ffff;
         3: return 32'(sb.eps);
         4: return -(32'(sb.eps) + 1);
         5: return near_zero();
         default: return $urandom;
      endcase
   endfunction

   // Mostly runs on a few qubits so that fusion and cancellation happen often;
   // the rest is end commands, unknown kinds and fully random fields.
   task automatic send_random_item();
      op_kind_type                op;
      logic [KIND_BITS-1:0]       kind;
      logic [31:0]                angle;
      logic [PORT_QUBIT_BITS-1:0] qa;
      logic [PORT_QUBIT_BITS-1:0] qb;
      logic [TAG_BITS-1:0]        tag;
      int                         pick;
      pick  = $urandom_range(0, 99);
      op    = OP_PUSH;
      kind  = KIND_BITS'($urandom_range(0, KIND_LAST_CODE));
      angle = $urandom;
      qa    = rnd_qb();
      qb    = rnd_qb();
      tag   = rnd_tag();
      if (pick < 7) begin
         op = OP_END;
      end else if (pick < 32) begin
         // Repeat the previous gate; rotations sometimes sum to near zero.
         kind = prev_kind;
         qa   = prev_qa;
         qb   = prev_qb;
         if (kind <= KIND_RZ && $urandom_range(0, 2) == 0) angle = -prev_angle + near_zero();
         else angle = pick_angle();
      end else if (pick < 48) begin
         kind  = KIND_BITS'($urandom_range(KIND_RX, KIND_RZ));
         qa    = PORT_QUBIT_BITS'($urandom_range(0, 3));
         angle = pick_angle();
      end else if (pick < 62) begin
         kind = KIND_CX;
         qa   = PORT_QUBIT_BITS'($urandom_range(0, 3));
         qb   = PORT_QUBIT_BITS'($urandom_range(0, 3));
      end else if (pick < 74) begin
         kind = KIND_H;
         qa   = PORT_QUBIT_BITS'($urandom_range(0, 3));
      end else if (pick < 82) begin
         kind  = KIND_BITS'($urandom_range(KIND_CU1, KIND_Y));
         qa    = PORT_QUBIT_BITS'($urandom_range(0, 3));
         qb    = PORT_QUBIT_BITS'($urandom_range(0, 3));
         angle = pick_angle();
      end else if (pick < 90) begin
         kind = KIND_BITS'($urandom_range(KIND_OPAQUE, KIND_LAST_CODE));
      end
      if (op == OP_PUSH) begin
         prev_kind  = kind;
         prev_angle = angle;
         prev_qa    = qa;
         prev_qb    = qb;
      end
      send_item(op, kind, angle, qa, qb, tag);
   endtask

   initial begin
      logic [EPS_BITS-1:0] eps_plan [PHASE_COUNT];
      eps_plan = '{16'hffff, 16'd1, 16'd300, 16'h0000, 16'd0, 16'd2};
      eps_plan[4] = EPS_BITS'($urandom);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      write_eps(16'd0);

      // Directed: fused zero, cx and h pairs and triples, angle wrap, extremes,
      // unused fields, unknown kinds, a zero rotation breaking an h pair,
      // and a flush with nothing pending.
      send_item(OP_PUSH, KIND_RX, 32'h0000_0100, 8'd1, rnd_qb(), rnd_tag());
      send_item(OP_PUSH, KIND_RX, 32'hffff_ff00, 8'd1, rnd_qb(), rnd_tag());
      send_item(OP_PUSH, KIND_RY, 32'd5, 8'd1, rnd_qb(), rnd_tag());
      repeat (5) send_item(OP_PUSH, KIND_CX, $urandom, 8'd2, 8'd3, rnd_tag());
      repeat (3) send_item(OP_PUSH, KIND_H, $urandom, 8'd4, rnd_qb(), rnd_tag());
      send_item(OP_PUSH, KIND_H, $urandom, 8'd5, rnd_qb(), rnd_tag());
      send_item(OP_PUSH, KIND_RZ, 32'h7fff_ffff, 8'd6, rnd_qb(), rnd_tag());
      send_item(OP_PUSH, KIND_RZ, 32'd1, 8'd6, rnd_qb(), rnd_tag());
      send_item(OP_PUSH, KIND_CU1, 32'h8000_0000, 8'hff, 8'hff, rnd_tag());
      send_item(OP_PUSH, KIND_X, $urandom, 8'd0, rnd_qb(), rnd_tag());
      send_item(OP_PUSH, KIND_Z, $urandom, 8'hff, rnd_qb(), rnd_tag());
      send_item(OP_PUSH, KIND_Y, $urandom, 8'h5a, rnd_qb(), rnd_tag());
      send_item(OP_PUSH, KIND_OPAQUE, $urandom, rnd_qb(), rnd_qb(), 16'hffff);
      send_item(OP_PUSH, KIND_LAST_CODE, $urandom, rnd_qb(), rnd_qb(), 16'h1234);
      send_item(OP_PUSH, KIND_H, $urandom, 8'd7, rnd_qb(), rnd_tag());
      send_item(OP_PUSH, KIND_RZ, 32'd0, 8'd7, rnd_qb(), rnd_tag());
      send_item(OP_PUSH, KIND_H, $urandom, 8'd7, rnd_qb(), rnd_tag());
      send_item(OP_END, rnd_kind(), $urandom, rnd_qb(), rnd_qb(), rnd_tag());
      send_item(OP_END, rnd_kind(), $urandom, rnd_qb(), rnd_qb(), rnd_tag());

      // Random phases, one threshold each; phase 2 and the last run without gaps.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_eps(eps_plan[p]);
         tx_gaps = (p != 2) && (p != PHASE_COUNT - 1);
         rx_gaps = tx_gaps;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // Let the result side catch up once with gates still held in the slots.
            if (p == 1 && i == PHASE_ITEMS / 2) wait_drained();
            send_random_item();
         end
         send_item(OP_END, rnd_kind(), $urandom, rnd_qb(), rnd_qb(), rnd_tag());
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d items with %0d end commands over %0d threshold settings; checked %0d gates.",
               sb.items, sb.flushes, eps_settings, sb.checked);
      $display("Fused %0d rotations, cancelled %0d cx and %0d h pairs, dropped %0d zero rotations.",
               sb.fused, sb.cx_pairs, sb.h_pairs, sb.zero_drops);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASS gate_stream_peephole_optimizer_unit");
      end else begin
         $display("FAIL gate_stream_peephole_optimizer_unit");
      end
      $finish;
   end

endmodule
